/* rtl/mts_pkg.sv */
// max tracking stack: shared constants, codes and types
// no dependencies
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

`default_nettype wire

/* rtl/max_tracking_stack_core.sv */
// Push and query words, and pops of an empty stack, go straight into the output register;
// other pops pass first through one read of both stack memories for the new tops.
// One push or query word is taken per cycle while the output is not stalled; a pop holds off
// the next word while it reads through the single read port of each stack memory.
// Reset empties both stacks by clearing the counts; memories are not cleared.
// Depends on mts_pkg.
`default_nettype none

module max_tracking_stack_core
    import mts_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire  [1:0]                i_operation,
    input  wire  signed [DATA_W-1:0]  i_value,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output logic signed [DATA_W-1:0]  o_current_max,
    output logic [1:0]                o_status
);

    logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] max_mem   [STACK_DEPTH];

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_vcnt, n_vcnt;
    logic [CNT_W-1:0]         r_mcnt, n_mcnt;
    logic signed [DATA_W-1:0] r_val_top, n_val_top;
    logic signed [DATA_W-1:0] r_max_top, n_max_top;
    logic                     r_pop_max, n_pop_max;
    logic signed [DATA_W-1:0] r_vrd, r_mrd;

    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_max, n_out_max;
    t_status                  r_out_status, n_out_status;

    logic                     w_accept;
    logic                     w_push_val;
    logic                     w_push_max;
    logic                     w_rd;
    logic [ADDR_W-1:0]        w_vraddr;
    logic [ADDR_W-1:0]        w_mraddr;
    logic [CNT_W-1:0]         w_vcnt_m2;
    logic [CNT_W-1:0]         w_mcnt_m2;

    assign o_in_stall    = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept      = i_in_valid && !o_in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_current_max = r_out_max;
    assign o_status      = r_out_status;

    assign w_vcnt_m2 = r_vcnt - CNT_W'(2);
    assign w_mcnt_m2 = r_mcnt - CNT_W'(2);
    assign w_vraddr  = w_vcnt_m2[ADDR_W-1:0];
    assign w_mraddr  = w_mcnt_m2[ADDR_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && t_op'(i_operation) == OP_POP && r_vcnt != '0) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_vcnt       = r_vcnt;
        n_mcnt       = r_mcnt;
        n_val_top    = r_val_top;
        n_max_top    = r_max_top;
        n_pop_max    = r_pop_max;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_max    = r_out_max;
        n_out_status = r_out_status;
        w_push_val   = 1'b0;
        w_push_max   = 1'b0;
        w_rd         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_operation))
                        OP_PUSH: begin
                            n_out_valid = 1'b1;
                            if (r_vcnt >= CNT_W'(STACK_DEPTH)) begin
                                n_out_status = ST_FULL;
                                n_out_max    = (r_mcnt == '0) ? '0 : r_max_top;
                            end else begin
                                w_push_val   = 1'b1;
                                n_vcnt       = r_vcnt + CNT_W'(1);
                                n_val_top    = i_value;
                                n_out_status = ST_OK;
                                if ((r_mcnt == '0 || i_value >= r_max_top)
                                    && r_mcnt < CNT_W'(STACK_DEPTH)) begin
                                    w_push_max = 1'b1;
                                    n_mcnt     = r_mcnt + CNT_W'(1);
                                    n_max_top  = i_value;
                                    n_out_max  = i_value;
                                end else begin
                                    n_out_max  = (r_mcnt == '0) ? '0 : r_max_top;
                                end
                            end
                        end
                        OP_POP: begin
                            if (r_vcnt == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                                n_out_max    = '0;
                            end else begin
                                w_rd      = 1'b1;
                                n_vcnt    = r_vcnt - CNT_W'(1);
                                n_pop_max = (r_mcnt != '0) && (r_val_top == r_max_top);
                                if (n_pop_max) begin
                                    n_mcnt = r_mcnt - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            if (r_vcnt == '0) begin
                                n_out_status = ST_EMPTY;
                                n_out_max    = '0;
                            end else begin
                                n_out_status = ST_OK;
                                n_out_max    = (r_mcnt == '0) ? '0 : r_max_top;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_val_top    = r_vrd;
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                if (r_pop_max) begin
                    n_max_top = r_mrd;
                end
                if (r_vcnt == '0 || r_mcnt == '0) begin
                    n_out_max = '0;
                end else begin
                    n_out_max = r_pop_max ? r_mrd : r_max_top;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push_val) begin
            value_mem[r_vcnt[ADDR_W-1:0]] <= i_value;
        end
        if (w_rd) begin
            r_vrd <= value_mem[w_vraddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_max) begin
            max_mem[r_mcnt[ADDR_W-1:0]] <= i_value;
        end
        if (w_rd) begin
            r_mrd <= max_mem[w_mraddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcnt      <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
            r_pop_max   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcnt      <= n_vcnt;
            r_mcnt      <= n_mcnt;
            r_out_valid <= n_out_valid;
            r_pop_max   <= n_pop_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val_top    <= n_val_top;
        r_max_top    <= n_max_top;
        r_out_max    <= n_out_max;
        r_out_status <= n_out_status;
    end

endmodule

`default_nettype wire

/* tb/mts_tb_pkg.sv */
// scoreboard for the max tracking stack testbench: tracks both stacks and queues expected words
// depends on mts_pkg

package mts_tb_pkg;

    import mts_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef struct packed {
        t_word   cur_max;
        t_status status;
    } t_max_word;

    class max_stack_scoreboard;

        t_word       value_mem [STACK_DEPTH];
        t_word       max_mem   [STACK_DEPTH];
        int unsigned value_cnt;
        int unsigned max_cnt;
        t_max_word   expected_q [$];
        int          errors;
        int          checked;
        int          full_hits;
        int          empty_hits;
        int          peak;

        function new();
            value_cnt  = 0;
            max_cnt    = 0;
            errors     = 0;
            checked    = 0;
            full_hits  = 0;
            empty_hits = 0;
            peak       = 0;
        endfunction

        function t_word max_top();
            if (max_cnt == 0) begin
                return '0;
            end
            return max_mem[max_cnt-1];
        endfunction

        function int unsigned depth();
            return value_cnt;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(logic [1:0] op, t_word value);
            t_max_word w;
            t_word     removed;
            w.status = ST_OK;
            case (op)
                OP_PUSH: begin
                    if (value_cnt >= STACK_DEPTH) begin
                        w.status = ST_FULL;
                        full_hits++;
                    end else begin
                        if (max_cnt == 0 || value >= max_top()) begin
                            if (max_cnt < STACK_DEPTH) begin
                                max_mem[max_cnt] = value;
                                max_cnt++;
                            end
                        end
                        value_mem[value_cnt] = value;
                        value_cnt++;
                    end
                end
                OP_POP: begin
                    if (value_cnt == 0) begin
                        w.status = ST_EMPTY;
                        empty_hits++;
                    end else begin
                        removed = value_mem[value_cnt-1];
                        value_cnt--;
                        if (max_cnt > 0 && removed == max_top()) begin
                            max_cnt--;
                        end
                    end
                end
                default: begin
                    if (value_cnt == 0) begin
                        w.status = ST_EMPTY;
                        empty_hits++;
                    end
                end
            endcase
            w.cur_max = (value_cnt == 0) ? '0 : max_top();
            if (value_cnt > peak) begin
                peak = value_cnt;
            end
            expected_q.push_back(w);
        endfunction

        function void check_word(t_word act_max, logic [1:0] act_status);
            t_max_word w;
            if (expected_q.size() == 0) begin
                errors++;
                $error("result word with nothing expected: current_max %0d status %0d",
                       act_max, act_status);
                return;
            end
            w = expected_q.pop_front();
            checked++;
            if (act_max !== w.cur_max) begin
                errors++;
                $error("current_max: expected %0d, actual %0d", w.cur_max, act_max);
            end
            if (act_status !== w.status) begin
                errors++;
                $error("status: expected %0d, actual %0d", w.status, act_status);
            end
        endfunction

    endclass

endpackage

/* tb/testbench.sv */
// top-level testbench for max_tracking_stack_core: directed and random push/pop/query words
// under varying idle and stall patterns, checked against the scoreboard in mts_tb_pkg
// depends on mts_pkg, mts_tb_pkg and the block's RTL

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;
    import mts_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 25;
    localparam int HOLD_WORDS   = 40;
    localparam int FULL_EXTRA   = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_operation = OP_PUSH;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_current_max;
    logic [1:0]               o_status;

    max_stack_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int words_sent     = 0;
    int cycles         = 0;

    max_tracking_stack_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_current_max (o_current_max),
        .o_status      (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
        $display("Mismatches found");
        $finish;
    end

    // result side: check accepted words, then pick the next stall
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_word(o_current_max, o_status);
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_word(input logic [1:0] op, input t_word val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid  <= 1'b0;
            i_operation <= 2'($urandom);
            i_value     <= $urandom;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_word(op, val);
        words_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() > 0);
    endtask

    function automatic t_word pick_value();
        int    sel;
        t_word top;
        sel = $urandom_range(9);
        top = sb.max_top();
        case (sel)
            0, 1, 2: return $urandom;
            3, 4:    return $signed($urandom_range(16)) - 8;
            5:       return top;
            6:       return top + 1;
            7:       return top - 1;
            8:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom & ~($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            return OP_PUSH;
        end else if (r < 80) begin
            return OP_POP;
        end else if (r < 90) begin
            return OP_QUERY;
        end
        return OP_UNUSED;
    endfunction

    task automatic run_segment();
        int    sel;
        int    n;
        t_word v;
        sel = $urandom_range(9);
        n   = $urandom_range(10, 1);
        if (sel <= 2 && sb.depth() > 300) begin
            sel = 3;
        end
        case (sel)
            0, 1, 2: begin
                repeat (n) send_word(OP_PUSH, pick_value());
            end
            3, 4: begin
                repeat (n) send_word(OP_POP, $urandom);
            end
            5: begin
                v = pick_value();
                repeat (n) send_word(OP_PUSH, v);
                repeat ($urandom_range(n + 1)) send_word(OP_POP, $urandom);
            end
            6, 7, 8: begin
                repeat (n) send_word(pick_op(), pick_value());
            end
            default: begin
                send_word(OP_QUERY, $urandom);
                send_word(OP_UNUSED, $urandom);
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target) begin
            run_segment();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty stack, extremes, duplicate maxima
        send_word(OP_POP, 32'sh7fffffff);
        send_word(OP_QUERY, 32'sh80000000);
        send_word(OP_UNUSED, '1);
        send_word(OP_PUSH, 0);
        send_word(OP_PUSH, 32'sh7fffffff);
        send_word(OP_PUSH, 32'sh80000000);
        send_word(OP_PUSH, 32'sh7fffffff);
        send_word(OP_QUERY, 0);
        send_word(OP_UNUSED, 0);
        send_word(OP_POP, 0);
        send_word(OP_QUERY, 0);
        send_word(OP_POP, 0);
        send_word(OP_POP, 0);
        send_word(OP_POP, 0);
        send_word(OP_POP, 0);
        send_word(OP_PUSH, -5);
        send_word(OP_PUSH, -5);
        send_word(OP_PUSH, -7);
        send_word(OP_POP, 0);
        send_word(OP_POP, 0);
        send_word(OP_PUSH, 32'shaaaaaaaa);
        send_word(OP_PUSH, 32'sh55555555);
        send_word(OP_POP, 0);
        send_word(OP_POP, 0);
        send_word(OP_POP, 0);
        wait_drained();

        // long output hold-off while words keep coming
        hold_req = HOLD_CYCLES;
        repeat (HOLD_WORDS) send_word(pick_op(), pick_value());
        wait_drained();

        // no idling: fill to the top, push past it, work at the boundary
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (sb.depth() < STACK_DEPTH) begin
            if ($urandom_range(1)) begin
                send_word(OP_PUSH, pick_value());
            end else begin
                send_word(OP_PUSH, sb.max_top() + $signed($urandom_range(3)));
            end
        end
        repeat (FULL_EXTRA) send_word(OP_PUSH, pick_value());
        send_word(OP_QUERY, $urandom);
        repeat (8) begin
            send_word(OP_POP, $urandom);
            send_word(OP_PUSH, pick_value());
            send_word(OP_PUSH, pick_value());
        end
        wait_drained();

        send_idle_pct  = 66;
        recv_stall_pct = 0;
        run_random(PHASE_WORDS);

        send_idle_pct  = 0;
        recv_stall_pct = 66;
        run_random(PHASE_WORDS);
        wait_drained();

        send_idle_pct  = 10;
        recv_stall_pct = 10;
        run_random(PHASE_WORDS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            sb.errors++;
            $error("%0d expected words never arrived", sb.pending());
        end
        $display("sent %0d words, checked %0d results in %0d cycles, peak depth %0d",
                 words_sent, sb.checked, cycles, sb.peak);
        $display("pushes onto a full stack: %0d, pops or queries on an empty stack: %0d",
                 sb.full_hits, sb.empty_hits);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mts_pkg.sv
rtl/max_tracking_stack_core.sv
tb/mts_tb_pkg.sv
tb/testbench.sv
